/* rtl/mbe_pkg.sv */
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the escape-time pixel unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int COORD_W = 32;
  localparam int PROD_W  = 2 * COORD_W;

  // multiplier row: each cell takes one digit of the second operand
  localparam int DIGIT_W   = 16;
  localparam int NUM_CELLS = COORD_W / DIGIT_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN       = 3'd0,
    REG_Y_ORIGIN       = 3'd1,
    REG_X_STEP         = 3'd2,
    REG_Y_STEP         = 3'd3,
    REG_IMAGE_WIDTH    = 3'd4,
    REG_MAX_ITERATIONS = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
  } pixel_in_t;

  typedef struct packed {
    logic [15:0] iteration_count;
    logic [23:0] pixel_index;
  } pixel_out_t;

  // word handed from cell to cell along the multiplier row
  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] z_re;
    logic signed [COORD_W-1:0] z_im;
    logic signed [PROD_W-1:0]  acc_rr;
    logic signed [PROD_W-1:0]  acc_ii;
    logic signed [PROD_W-1:0]  acc_ri;
  } mul_stage_t;

endpackage

/* rtl/mbe_mul_cell.sv */
// ----------------------------------------------------------------------------
// mbe_mul_cell
// One cell of the multiplier row: adds one digit's partial products of
// z_re*z_re, z_im*z_im and z_re*z_im to the running sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbe_mul_cell #(
  parameter int DIGIT = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  mbe_pkg::mul_stage_t stage_in,
  output mbe_pkg::mul_stage_t stage_out
);
  import mbe_pkg::*;

  localparam int LSB     = DIGIT * DIGIT_W;
  localparam bit TOP_DIG = (DIGIT == NUM_CELLS - 1);

  logic signed [DIGIT_W:0]         dig_re;
  logic signed [DIGIT_W:0]         dig_im;
  logic signed [COORD_W+DIGIT_W:0] pp_rr;
  logic signed [COORD_W+DIGIT_W:0] pp_ii;
  logic signed [COORD_W+DIGIT_W:0] pp_ri;

  logic                      valid;
  logic signed [COORD_W-1:0] z_re;
  logic signed [COORD_W-1:0] z_im;
  logic signed [PROD_W-1:0]  acc_rr;
  logic signed [PROD_W-1:0]  acc_ii;
  logic signed [PROD_W-1:0]  acc_ri;

  // lower digits are unsigned, the top digit carries the sign
  assign dig_re = {(TOP_DIG ? stage_in.z_re[LSB+DIGIT_W-1] : 1'b0),
                   stage_in.z_re[LSB +: DIGIT_W]};
  assign dig_im = {(TOP_DIG ? stage_in.z_im[LSB+DIGIT_W-1] : 1'b0),
                   stage_in.z_im[LSB +: DIGIT_W]};

  assign pp_rr = stage_in.z_re * dig_re;
  assign pp_ii = stage_in.z_im * dig_im;
  assign pp_ri = stage_in.z_re * dig_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    z_re   <= stage_in.z_re;
    z_im   <= stage_in.z_im;
    acc_rr <= stage_in.acc_rr + (PROD_W'(pp_rr) <<< LSB);
    acc_ii <= stage_in.acc_ii + (PROD_W'(pp_ii) <<< LSB);
    acc_ri <= stage_in.acc_ri + (PROD_W'(pp_ri) <<< LSB);
  end

  assign stage_out = '{valid: valid, z_re: z_re, z_im: z_im,
                       acc_rr: acc_rr, acc_ii: acc_ii, acc_ri: acc_ri};

endmodule

/* rtl/mandelbrot_escape_time_pixel_unit.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_unit
// Escape-time count of one pixel in signed fixed point, plus its linear index.
// The pixel loop makes count+1 passes when the point escapes, and
// max_iterations passes otherwise.
// Each pass is the two-cell multiplier row plus the z update register.
// One pixel at a time; the next pixel is taken while a result waits.
// Reset (synchronous) restores register defaults and empties both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_unit #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 28
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  mbe_pkg::pixel_in_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mbe_pkg::pixel_out_t                 out_word
);
  import mbe_pkg::*;

  localparam int W_BITS = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = 12 + W_BITS + 1;
  localparam int CP_W   = COORD_W + 13;
  localparam int WIDE_W = PROD_W + 2;

  localparam logic signed [WIDE_W-1:0] ESC_LIMIT = 66'sd4 <<< FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] SAT_HI    = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_LO    = -66'sd2147483648;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_CINIT = 5'b00100,
    ST_ITER  = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = COORD_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = COORD_W'(SAT_LO);
    end else begin
      r = COORD_W'(v);
    end
    return r;
  endfunction

  // configuration
  logic signed [COORD_W-1:0] x_origin;
  logic signed [COORD_W-1:0] y_origin;
  logic signed [COORD_W-1:0] x_step;
  logic signed [COORD_W-1:0] y_step;
  logic [12:0]               image_width;
  logic [15:0]               max_iterations;

  state_t                    state;
  logic [11:0]               col_q;
  logic [11:0]               row_q;
  logic signed [CP_W-1:0]    prod_x;
  logic signed [CP_W-1:0]    prod_y;
  logic [23:0]               pix_index;
  logic signed [COORD_W-1:0] c_re;
  logic signed [COORD_W-1:0] c_im;
  logic signed [COORD_W-1:0] z_re;
  logic signed [COORD_W-1:0] z_im;
  logic [15:0]               count;
  logic                      launch;

  logic [W_BITS-1:0]         width_eff;
  logic [IDX_W-1:0]          idx_full;
  logic signed [COORD_W-1:0] c_re_sat;
  logic signed [COORD_W-1:0] c_im_sat;
  logic signed [WIDE_W-1:0]  sr;
  logic signed [WIDE_W-1:0]  si;
  logic signed [WIDE_W-1:0]  new_im;
  logic                      escaped;
  logic [15:0]               count_inc;
  logic signed [COORD_W-1:0] z_re_upd;
  logic signed [COORD_W-1:0] z_im_upd;
  logic                      out_load;

  mul_stage_t chain [NUM_CELLS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin       <= 32'shE000_0000;
      y_origin       <= 32'shF000_0000;
      x_step         <= 32'sd262144;
      y_step         <= 32'sd262144;
      image_width    <= 13'd1024;
      max_iterations <= 16'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_X_ORIGIN:       x_origin       <= cfg_data;
        REG_Y_ORIGIN:       y_origin       <= cfg_data;
        REG_X_STEP:         x_step         <= cfg_data;
        REG_Y_STEP:         y_step         <= cfg_data;
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[12:0];
        REG_MAX_ITERATIONS: max_iterations <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // index path, widths above MAX_DIM are clamped
  always_comb begin
    if (32'(image_width) > 32'(MAX_DIM)) begin
      width_eff = W_BITS'(MAX_DIM);
    end else begin
      width_eff = W_BITS'(image_width);
    end
    idx_full = IDX_W'(row_q) * IDX_W'(width_eff) + IDX_W'(col_q);
  end

  assign c_re_sat = sat32(WIDE_W'(x_origin) + WIDE_W'(prod_x));
  assign c_im_sat = sat32(WIDE_W'(y_origin) + WIDE_W'(prod_y));

  // multiplier row
  assign chain[0] = '{valid: launch, z_re: z_re, z_im: z_im,
                      acc_rr: '0, acc_ii: '0, acc_ri: '0};

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    mbe_mul_cell #(.DIGIT(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (chain[g]),
      .stage_out (chain[g+1])
    );
  end

  // z update from the finished products
  always_comb begin
    sr        = WIDE_W'(chain[NUM_CELLS].acc_rr >>> FRAC_BITS);
    si        = WIDE_W'(chain[NUM_CELLS].acc_ii >>> FRAC_BITS);
    new_im    = WIDE_W'(chain[NUM_CELLS].acc_ri >>> (FRAC_BITS - 1));
    escaped   = (sr + si) > ESC_LIMIT;
    z_re_upd  = sat32(WIDE_W'(c_re) + (sr - si));
    z_im_upd  = sat32(WIDE_W'(c_im) + new_im);
    count_inc = count + 16'd1;
  end

  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_HOLD) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      launch <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state <= ST_CINIT;
        end
        ST_CINIT: begin
          if (max_iterations == 16'd0) begin
            state <= ST_HOLD;
          end else begin
            launch <= 1'b1;
            state  <= ST_ITER;
          end
        end
        ST_ITER: begin
          if (chain[NUM_CELLS].valid) begin
            if (escaped || count_inc == max_iterations) begin
              state <= ST_HOLD;
            end else begin
              launch <= 1'b1;
            end
          end
        end
        ST_HOLD: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      col_q <= in_word.column;
      row_q <= in_word.row;
    end
    if (state == ST_SETUP) begin
      prod_x    <= $signed({1'b0, col_q}) * x_step;
      prod_y    <= $signed({1'b0, row_q}) * y_step;
      pix_index <= 24'(idx_full);
    end
    if (state == ST_CINIT) begin
      c_re  <= c_re_sat;
      c_im  <= c_im_sat;
      z_re  <= c_re_sat;
      z_im  <= c_im_sat;
      count <= 16'd0;
    end
    if (state == ST_ITER && chain[NUM_CELLS].valid && !escaped) begin
      z_re  <= z_re_upd;
      z_im  <= z_im_upd;
      count <= count_inc;
    end
  end

  // output register, lets the next pixel start while this word waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word.iteration_count <= count;
      out_word.pixel_index     <= pix_index;
    end
  end

endmodule

/* tb/sv/mandelbrot_escape_time_pixel_unit_tb.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_unit_tb
// Self-checking bench for the escape-time pixel unit. A short table of
// directed pixels under fixed views (reset values, zero limit, full limit,
// saturated coordinates, clamped and zero widths) is followed by random
// views and random pixels. Each accepted pixel is scored by its known table
// result or a local fixed-point escape-time model; words are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_unit_tb;
  import mbe_pkg::*;

  localparam int FRAC_BITS       = 28;
  localparam int MAX_DIM         = 4096;
  localparam int STALL_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int DEEP_PHASE      = 1;
  localparam int STEADY_PHASE    = 4;
  localparam int WILD_PHASE      = 6;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] x_org;
    logic signed [31:0] y_org;
    logic signed [31:0] x_stp;
    logic signed [31:0] y_stp;
    logic [12:0]        width;
    logic [15:0]        limit;
  } view_cfg_t;

  typedef struct packed {
    logic [2:0] view;
    pixel_in_t  px;
    logic       known;
    pixel_out_t result;
  } directed_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  pixel_in_t             in_word;
  logic                  out_valid;
  logic                  out_ready;
  pixel_out_t            out_word;

  view_cfg_t     active_view;
  view_cfg_t     views [6];
  directed_row_t plan [$];
  pixel_out_t    awaited_pixels [$];
  pixel_out_t    head;
  bit            steady;
  int            mismatch_count;
  int            idle_cycles;

  mandelbrot_escape_time_pixel_unit #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic view_cfg_t make_view(input logic signed [31:0] x_org,
                                          input logic signed [31:0] y_org,
                                          input logic signed [31:0] x_stp,
                                          input logic signed [31:0] y_stp,
                                          input logic [12:0] width,
                                          input logic [15:0] limit);
    view_cfg_t v;
    v.x_org = x_org;
    v.y_org = y_org;
    v.x_stp = x_stp;
    v.y_stp = y_stp;
    v.width = width;
    v.limit = limit;
    return v;
  endfunction

  // escape-time count and linear index of one pixel under the active view
  function automatic pixel_out_t escape_pixel(input pixel_in_t px);
    longint     c_re, c_im, z_re, z_im, sr, si, z_ri, eff_w, lin;
    longint     four;
    int         n;
    pixel_out_t r;
    four = longint'(4) << FRAC_BITS;
    c_re = clamp32(longint'($signed(active_view.x_org)) +
                   longint'(px.column) * longint'($signed(active_view.x_stp)));
    c_im = clamp32(longint'($signed(active_view.y_org)) +
                   longint'(px.row) * longint'($signed(active_view.y_stp)));
    z_re = c_re;
    z_im = c_im;
    for (n = 0; n < int'(active_view.limit); n++) begin
      sr = (z_re * z_re) >>> FRAC_BITS;
      si = (z_im * z_im) >>> FRAC_BITS;
      if (sr + si > four) break;
      z_ri = (z_re * z_im) >>> (FRAC_BITS - 1);
      z_re = clamp32(c_re + sr - si);
      z_im = clamp32(c_im + z_ri);
    end
    eff_w = (active_view.width > MAX_DIM) ? longint'(MAX_DIM) : longint'(active_view.width);
    lin = longint'(px.row) * eff_w + longint'(px.column);
    r.iteration_count = n[15:0];
    r.pixel_index = lin[23:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch, %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(input int view, input int column, input int row, input bit known,
                         input int count, input int index);
    directed_row_t d;
    d.view = view[2:0];
    d.px.column = column[11:0];
    d.px.row = row[11:0];
    d.known = known;
    d.result.iteration_count = count[15:0];
    d.result.pixel_index = index[23:0];
    plan.push_back(d);
  endtask

  // called at a falling edge; leaves at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  task automatic program_view(input view_cfg_t v, input bit junk);
    logic [31:0] pad;
    pad = junk ? $urandom : 32'd0;
    write_reg(REG_X_ORIGIN, v.x_org);
    write_reg(REG_SPARE_6, $urandom);
    write_reg(REG_Y_ORIGIN, v.y_org);
    write_reg(REG_X_STEP, v.x_stp);
    write_reg(REG_Y_STEP, v.y_stp);
    write_reg(REG_IMAGE_WIDTH, {pad[31:13], v.width});
    write_reg(REG_MAX_ITERATIONS, {pad[31:16], v.limit});
    write_reg(REG_SPARE_7, $urandom);
    cfg_write <= 1'b0;
    active_view = v;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_pixel(input pixel_in_t px, input bit known, input pixel_out_t result);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_pixels.push_back(known ? result : escape_pixel(px));
    @(negedge clk);
  endtask

  function automatic logic [11:0] pick_coord(input int dim);
    if ($urandom_range(0, 9) == 0) return 12'($urandom);
    return 12'($urandom_range(0, dim - 1));
  endfunction

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_pixels.size() == 0) begin
        report_mismatch("word with nothing pending, index", out_word.pixel_index, -1);
      end else begin
        head = awaited_pixels.pop_front();
        if (out_word.iteration_count !== head.iteration_count)
          report_mismatch("iteration_count", out_word.iteration_count, head.iteration_count);
        if (out_word.pixel_index !== head.pixel_index)
          report_mismatch("pixel_index", out_word.pixel_index, head.pixel_index);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          i, k, phase, dim, current;
    int          xs, ys, x0, y0;
    logic [12:0] w;
    logic [15:0] lim;
    pixel_in_t   px;

    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_X_ORIGIN;
    cfg_data = '0;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;
    steady = 1'b0;
    mismatch_count = 0;
    idle_cycles = 0;

    // view 0 is the reset state and is never written
    views[0] = make_view(-32'sd536870912, -32'sd268435456, 32'sd262144, 32'sd262144,
                         13'd1024, 16'd256);
    views[1] = make_view(0, 0, 0, 0, 13'd0, 16'd0);
    views[2] = make_view(0, 0, 0, 0, 13'd8191, 16'd65535);
    views[3] = make_view(S32_MAX, S32_MAX, S32_MAX, S32_MAX, 13'd4096, 16'd100);
    views[4] = make_view(S32_MIN, S32_MIN, S32_MIN, S32_MIN, 13'd1, 16'd1000);
    views[5] = make_view(-32'sd536870912, 0, 32'sd268435456, 32'sd268435456,
                         13'd16, 16'd64);
    active_view = views[0];

    //      view  col   row  known count  index
    add_row(0,    0,    0,    1,    0,     0);         // c = -2 - i escapes at once
    add_row(0,    4095, 4095, 1,    0,     4197375);
    add_row(0,    1536, 1024, 1,    256,   1050112);   // c = -0.5 never escapes
    add_row(0,    1000, 900,  0,    0,     0);
    add_row(0,    700,  1100, 0,    0,     0);
    add_row(1,    4095, 4095, 1,    0,     4095);      // zero limit, zero width
    add_row(1,    0,    0,    1,    0,     0);
    add_row(1,    2048, 1,    1,    0,     2048);
    add_row(2,    4095, 4095, 1,    65535, 16777215);  // width clamped, full limit
    add_row(3,    4095, 4095, 1,    0,     16777215);  // saturated high
    add_row(3,    0,    0,    1,    0,     0);
    add_row(3,    1,    0,    1,    0,     1);
    add_row(4,    4095, 0,    1,    0,     4095);      // saturated low, column past width
    add_row(4,    0,    4095, 1,    0,     4095);
    add_row(4,    4095, 4095, 1,    0,     8190);
    add_row(5,    0,    0,    0,    0,     0);         // c = -2 sits on the escape bound
    add_row(5,    4,    0,    0,    0,     0);         // c = 2
    add_row(5,    2,    0,    1,    64,    2);         // c = 0
    add_row(5,    1,    1,    0,    0,     0);
    add_row(5,    3,    2,    0,    0,     0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    current = 0;
    for (i = 0; i < plan.size(); i++) begin
      if (int'(plan[i].view) != current) begin
        wait_for_results();
        current = plan[i].view;
        program_view(views[current], 1'b0);
      end
      send_pixel(plan[i].px, plan[i].known, plan[i].result);
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      dim = $urandom_range(16, 4096);
      case ($urandom_range(0, 9))
        0:       w = 13'd0;
        1:       w = 13'($urandom_range(4097, 8191));
        default: w = 13'($urandom_range(1, 4096));
      endcase
      lim = (phase == DEEP_PHASE) ? 16'd256 : 16'($urandom_range(0, 48));
      if (phase == WILD_PHASE) begin
        program_view(make_view($urandom, $urandom, $urandom, $urandom, w, lim), 1'b1);
      end else begin
        // roughly a 3.0 by 2.5 window over the set, stepped across dim pixels
        xs = (3 << 28) / dim;
        ys = (5 << 27) / dim;
        x0 = -(9 << 26) + $urandom_range(0, 1 << 24);
        y0 = -(5 << 26) + $urandom_range(0, 1 << 24);
        if ($urandom_range(0, 7) == 0) begin
          xs = -xs;
          x0 = 3 << 26;
        end
        program_view(make_view(x0, y0, xs, ys, w, lim), 1'b1);
      end
      steady = (phase == STEADY_PHASE);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(0, 99) == 0) wait_for_results();
        px.column = pick_coord(dim);
        px.row = pick_coord(dim);
        send_pixel(px, 1'b0, '0);
      end
      steady = 1'b0;
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
